// ----- rtl/unknown_cell_window_detector_macros.svh -----
// Assertion shorthands used by the checker file.
`ifndef UNKNOWN_CELL_WINDOW_DETECTOR_MACROS_SVH
`define UNKNOWN_CELL_WINDOW_DETECTOR_MACROS_SVH

// Clocked assertion, switched off while reset is high.
`define UCWD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define UCWD_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/ucwd_pkg.sv -----
package ucwd_pkg;

  localparam int MAX_WINDOW   = 16;
  localparam int GRID_COLUMNS = 1024;

  localparam int VAL_W     = 7;
  localparam int WIN_W     = 5;
  localparam int RUN_W     = $clog2(MAX_WINDOW + 1);
  localparam int COL_W     = $clog2(GRID_COLUMNS);
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLUMNS - 1);
  localparam logic [RUN_W-1:0] RUN_FULL = RUN_W'(MAX_WINDOW);
  // fill mark value meaning no column written yet this frame
  localparam logic [COL_W:0]   NONE_FILLED = (COL_W + 1)'(GRID_COLUMNS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREE_MAX     = 2'd0,
    REG_OCCUPIED_MIN = 2'd1,
    REG_WINDOW_SIZE  = 2'd2
  } ucwd_reg_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             unknown;
    logic             in_area;
    logic             row_start;
    logic             frame_start;
  } ucwd_item_t;

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run);
    return (run >= RUN_FULL) ? RUN_FULL : RUN_W'(run + 1'b1);
  endfunction

endpackage

// ----- rtl/ucwd_front.sv -----
module ucwd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ucwd_pkg::VAL_W-1:0]     occupancy,
  input  logic                           in_area,
  input  logic                           row_start,
  input  logic                           frame_start,
  input  logic [ucwd_pkg::VAL_W-1:0]     free_max,
  input  logic [ucwd_pkg::VAL_W-1:0]     occupied_min,
  input  logic                           q_full,
  output logic                           push,
  output ucwd_pkg::ucwd_item_t           item
);

  logic [ucwd_pkg::COL_W-1:0] next_col;
  logic [ucwd_pkg::COL_W-1:0] next_col_next;
  logic [ucwd_pkg::COL_W-1:0] col;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    col = (row_start || frame_start) ? ucwd_pkg::LAST_COL : next_col;
    next_col_next = (col == '0) ? ucwd_pkg::LAST_COL : col - 1'b1;
    item.col         = col;
    item.unknown     = (occupancy >= free_max) && (occupancy <= occupied_min);
    item.in_area     = in_area;
    item.row_start   = row_start || frame_start;
    item.frame_start = frame_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_col <= ucwd_pkg::LAST_COL;
    end else if (push) begin
      next_col <= next_col_next;
    end
  end

endmodule

// ----- rtl/ucwd_queue.sv -----
module ucwd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ucwd_pkg::ucwd_item_t push_item,
  input  logic                 pop,
  output logic                 full,
  output logic                 head_valid,
  output ucwd_pkg::ucwd_item_t head
);

  ucwd_pkg::ucwd_item_t        entries [ucwd_pkg::QUEUE_DEPTH];
  logic [ucwd_pkg::QPTR_W-1:0] wr_ptr;
  logic [ucwd_pkg::QPTR_W-1:0] rd_ptr;
  logic [ucwd_pkg::QCNT_W-1:0] count;
  logic [ucwd_pkg::QCNT_W-1:0] count_next;

  assign full       = (count == ucwd_pkg::QCNT_W'(ucwd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

// ----- rtl/ucwd_back.sv -----
module ucwd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  ucwd_pkg::ucwd_item_t       head,
  output logic                       pop,
  input  logic [ucwd_pkg::RUN_W-1:0] win,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       occluded,
  output logic                       area_occluded
);

  logic [ucwd_pkg::RUN_W-1:0] col_runs [ucwd_pkg::GRID_COLUMNS];

  // compute stage
  logic                       b1_valid;
  ucwd_pkg::ucwd_item_t       b1;
  logic                       b1_fwd;
  logic                       b1_fresh;
  logic [ucwd_pkg::RUN_W-1:0] b1_fwd_run;
  logic [ucwd_pkg::RUN_W-1:0] mem_q;

  logic [ucwd_pkg::RUN_W-1:0] row_run;
  logic                       area_flag;
  // lowest column written this frame; columns below it still read as full
  logic [ucwd_pkg::COL_W:0]   filled_low;

  logic                       adv;
  logic                       done;
  logic [ucwd_pkg::RUN_W-1:0] prev_run;
  logic [ucwd_pkg::RUN_W-1:0] crun;
  logic [ucwd_pkg::RUN_W-1:0] rr_base;
  logic [ucwd_pkg::RUN_W-1:0] row_run_next;
  logic                       occ;
  logic                       area_flag_next;
  logic [ucwd_pkg::COL_W:0]   filled_low_next;
  logic                       fwd_new;
  logic                       fresh_new;

  assign adv  = !out_valid || !out_stall;
  assign pop  = adv && head_valid;
  assign done = adv && b1_valid;

  always_comb begin
    if (b1_fwd) begin
      prev_run = b1_fwd_run;
    end else if (b1_fresh) begin
      prev_run = ucwd_pkg::RUN_FULL;
    end else begin
      prev_run = mem_q;
    end
    crun    = b1.unknown ? ucwd_pkg::bump(prev_run) : '0;
    rr_base = b1.row_start ? ucwd_pkg::RUN_FULL : row_run;
    row_run_next = (crun >= win) ? ucwd_pkg::bump(rr_base) : '0;
    occ = (row_run_next >= win);
    area_flag_next = (b1.frame_start ? 1'b0 : area_flag) || (occ && b1.in_area);

    filled_low_next = filled_low;
    if (done) begin
      filled_low_next = b1.frame_start ? ucwd_pkg::NONE_FILLED : filled_low;
      if ({1'b0, b1.col} < filled_low_next) begin
        filled_low_next = {1'b0, b1.col};
      end
    end

    // same column written by the older item at this edge: take its run
    fwd_new   = done && !head.frame_start && (b1.col == head.col);
    fresh_new = head.frame_start || ({1'b0, head.col} < filled_low_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      row_run    <= ucwd_pkg::RUN_FULL;
      area_flag  <= 1'b0;
      filled_low <= ucwd_pkg::NONE_FILLED;
    end else begin
      filled_low <= filled_low_next;
      if (adv) begin
        b1_valid  <= head_valid;
        out_valid <= b1_valid;
      end
      if (done) begin
        row_run   <= row_run_next;
        area_flag <= area_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1         <= head;
      b1_fwd     <= fwd_new;
      b1_fresh   <= fresh_new;
      b1_fwd_run <= crun;
      mem_q      <= col_runs[head.col];
    end
    if (done) begin
      col_runs[b1.col] <= crun;
      occluded         <= occ;
      area_occluded    <= area_flag_next;
    end
  end

endmodule

// ----- rtl/unknown_cell_window_detector.sv -----
// Unknown-cell window detector.
// Input channel (in_valid / in_stall): one occupancy cell per transaction in
// reverse raster order, with in_area, row_start and frame_start marks.
// Output channel (out_valid / out_stall): one result per input cell, in order:
// occluded (window anchored at the cell is all unknown) and the sticky
// area_occluded flag of the current frame.
// Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
// always high; write only while no cell is in flight.
// A cell passes the queue, the compute register and the output registers.
// Throughput: one cell per cycle while out_stall is low, set by the single
// read-modify-write of the column run memory, with same-column results forwarded.
// A two-entry queue sits between the classifying front and the run update; a
// stalled output fills it and in_stall is high while the queue is full.
// Reset: control and config registers return to defaults; all column runs read
// as full through a per-frame fill mark, so no clearing pass is needed and cells
// are accepted in the first cycle after reset.
module unknown_cell_window_detector (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ucwd_pkg::VAL_W-1:0]         occupancy,
  input  logic                               in_area,
  input  logic                               row_start,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               occluded,
  output logic                               area_occluded,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ucwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ucwd_pkg::VAL_W-1:0]         cfg_data
);

  logic [ucwd_pkg::VAL_W-1:0] free_max;
  logic [ucwd_pkg::VAL_W-1:0] occupied_min;
  logic [ucwd_pkg::WIN_W-1:0] window_size;
  logic [ucwd_pkg::RUN_W-1:0] win;

  logic                 q_full;
  logic                 push;
  ucwd_pkg::ucwd_item_t push_item;
  logic                 pop;
  logic                 head_valid;
  ucwd_pkg::ucwd_item_t head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_max     <= ucwd_pkg::VAL_W'(0);
      occupied_min <= ucwd_pkg::VAL_W'(100);
      window_size  <= ucwd_pkg::WIN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ucwd_pkg::REG_FREE_MAX:     free_max     <= cfg_data;
        ucwd_pkg::REG_OCCUPIED_MIN: occupied_min <= cfg_data;
        ucwd_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[ucwd_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // windows above the run limit are clamped
  assign win = (window_size > ucwd_pkg::WIN_W'(ucwd_pkg::MAX_WINDOW)) ?
               ucwd_pkg::RUN_FULL : ucwd_pkg::RUN_W'(window_size);

  ucwd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .occupancy    (occupancy),
    .in_area      (in_area),
    .row_start    (row_start),
    .frame_start  (frame_start),
    .free_max     (free_max),
    .occupied_min (occupied_min),
    .q_full       (q_full),
    .push         (push),
    .item         (push_item)
  );

  ucwd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ucwd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .win           (win),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .occluded      (occluded),
    .area_occluded (area_occluded)
  );

endmodule

// ----- rtl/ucwd_checker.sv -----
`include "unknown_cell_window_detector_macros.svh"

module ucwd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic occluded,
  input logic area_occluded
);

  `UCWD_ASSERT(a_in_hold, clk, rst, in_valid && in_stall |=> in_valid, "input valid dropped while stalled")
  `UCWD_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(occluded) && $stable(area_occluded), "output changed while stalled")
  // input backpressure only follows a stalled output transaction
  `UCWD_ASSERT(a_stall_cause, clk, rst, in_stall |-> $past(out_valid && out_stall), "in_stall without output stall")
  `UCWD_ASSERT_NR(a_reset_clear, clk, rst |=> !out_valid && !in_stall, "not empty after reset")

endmodule

bind unknown_cell_window_detector ucwd_checker u_chk (.*);
